@@ rtl/cpp_pkg.sv @@
package cpp_pkg;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_SHORT       = 4'd1,
		ST_MAGIC       = 4'd2,
		ST_LENGTH      = 4'd3,
		ST_RATE        = 4'd4,
		ST_NO_CC       = 4'd5,
		ST_TC_SHORT    = 4'd6,
		ST_TC_MARKER   = 4'd7,
		ST_TC_HOURS    = 4'd8,
		ST_TC_MINUTES  = 4'd9,
		ST_TC_FRAMES   = 4'd10,
		ST_CC_SHORT    = 4'd11,
		ST_CC_MARKER   = 4'd12,
		ST_CC_RESERVED = 4'd13
	} cpp_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SHOW
	} cpp_back_state_t;

	// byte offsets inside the packet
	localparam logic [7:0] POS_MAGIC_HI  = 8'd0;
	localparam logic [7:0] POS_MAGIC_LO  = 8'd1;
	localparam logic [7:0] POS_LENGTH    = 8'd2;
	localparam logic [7:0] POS_RATE      = 8'd3;
	localparam logic [7:0] POS_FLAGS     = 8'd4;
	localparam logic [7:0] POS_TC_MARKER = 8'd7;
	localparam logic [7:0] POS_TC_HOURS  = 8'd8;
	localparam logic [7:0] POS_TC_MIN    = 8'd9;
	localparam logic [7:0] POS_TC_SEC    = 8'd10;
	localparam logic [7:0] POS_TC_FRAMES = 8'd11;
	localparam logic [7:0] CC_START_TC   = 8'd12;
	localparam logic [7:0] CC_START_NOTC = 8'd7;
	localparam logic [7:0] MIN_LENGTH    = 8'd10;
	localparam logic [7:0] POS_MAX       = 8'd255;

	localparam logic [7:0] MAGIC_HI  = 8'h96;
	localparam logic [7:0] MAGIC_LO  = 8'h69;
	localparam logic [7:0] TC_MARKER = 8'h71;
	localparam logic [7:0] CC_MARKER = 8'h72;

	localparam logic [7:0] LEN_TC_MIN    = 8'd12;
	localparam logic [7:0] LEN_NOTC_MIN  = 8'd9;
	localparam logic [7:0] LEN_TC_FULL   = 8'd14;

	typedef struct packed {
		cpp_status_t status;
		logic [4:0]  count;
		logic [7:0]  rate;
		logic        tc_present;
		logic [5:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [5:0]  frames;
		logic        second_field;
		logic        drop_frame;
		logic        bank;
	} cpp_desc_t;

	// tens * 10 + units
	function automatic logic [6:0] bcd_value(logic [2:0] tens, logic [3:0] units);
		logic [6:0] t;
		t = {4'd0, tens};
		return (t << 3) + (t << 1) + {3'd0, units};
	endfunction

endpackage

@@ rtl/cpp_desc_fifo.sv @@
module cpp_desc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cpp_pkg::cpp_desc_t  push_desc,
	input  logic                pop,
	output cpp_pkg::cpp_desc_t  head,
	output logic                full,
	output logic                empty
);

	cpp_pkg::cpp_desc_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/cpp_front.sv @@
module cpp_front #(
	parameter int MAX_TRIPLETS = 31,
	parameter int TW           = $clog2(MAX_TRIPLETS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          packet_byte,
	input  logic                final_byte,
	input  logic                fifo_full,
	output logic                push,
	output cpp_pkg::cpp_desc_t  push_desc,
	output logic                wr_en,
	output logic [TW:0]         wr_addr,
	output logic [23:0]         wr_data
);

	localparam logic [4:0] MAX_CNT = 5'(MAX_TRIPLETS);

	logic [7:0]           pos_q, pos_n;
	logic [7:0]           hlen_q, hlen_n;
	cpp_pkg::cpp_status_t err_q, err_n;
	logic [7:0]           flags_q, flags_n;
	logic [7:0]           rate_q, rate_n;
	logic [4:0]           exp_q, exp_n;
	logic [15:0]          part_q, part_n;
	logic                 magic_q, magic_n;
	logic [4:0]           tidx_q, tidx_n;
	logic [1:0]           phase_q, phase_n;
	logic                 bank_q, bank_n;
	logic [5:0]           hours_q, hours_n;
	logic [6:0]           min_q, min_n;
	logic [6:0]           sec_q, sec_n;
	logic [5:0]           frames_q, frames_n;
	logic                 sfield_q, sfield_n;
	logic                 drop_q, drop_n;

	logic                 acc;
	logic                 tc;
	logic [7:0]           cc_start;
	logic [8:0]           h9;
	logic [8:0]           need;
	logic [8:0]           cnt3;
	logic [6:0]           bcd_tmp;
	cpp_pkg::cpp_status_t fin_status;

	always_comb begin
		acc        = byte_valid && !fifo_full;
		byte_stall = fifo_full;

		pos_n    = pos_q;
		hlen_n   = hlen_q;
		err_n    = err_q;
		flags_n  = flags_q;
		rate_n   = rate_q;
		exp_n    = exp_q;
		part_n   = part_q;
		magic_n  = magic_q;
		tidx_n   = tidx_q;
		phase_n  = phase_q;
		bank_n   = bank_q;
		hours_n  = hours_q;
		min_n    = min_q;
		sec_n    = sec_q;
		frames_n = frames_q;
		sfield_n = sfield_q;
		drop_n   = drop_q;

		wr_en    = 1'b0;
		wr_addr  = {bank_q, tidx_q[TW-1:0]};
		wr_data  = {part_q, packet_byte};
		push     = 1'b0;
		push_desc = '0;
		fin_status = cpp_pkg::ST_OK;

		tc       = flags_q[7];
		cc_start = tc ? cpp_pkg::CC_START_TC : cpp_pkg::CC_START_NOTC;
		h9       = {1'b0, hlen_q};
		need     = {1'b0, cc_start} + 9'd2;
		cnt3     = {3'd0, packet_byte[4:0], 1'b0} + {4'd0, packet_byte[4:0]};
		bcd_tmp  = '0;

		if (pos_q == cpp_pkg::POS_MAGIC_HI) begin
			magic_n = (packet_byte == cpp_pkg::MAGIC_HI);
		end else if (pos_q == cpp_pkg::POS_MAGIC_LO) begin
			magic_n = magic_q && (packet_byte == cpp_pkg::MAGIC_LO);
		end else if (pos_q == cpp_pkg::POS_LENGTH) begin
			hlen_n = packet_byte;
		end else if (pos_q == cpp_pkg::POS_RATE) begin
			rate_n = packet_byte;
			if (!(packet_byte[3:0] == 4'hf && packet_byte[7:4] >= 4'd1
					&& packet_byte[7:4] <= 4'd8) && err_q == cpp_pkg::ST_OK) begin
				err_n = cpp_pkg::ST_RATE;
			end
		end else if (pos_q == cpp_pkg::POS_FLAGS) begin
			flags_n = packet_byte;
			if (err_q == cpp_pkg::ST_OK) begin
				if (!packet_byte[6]) begin
					err_n = cpp_pkg::ST_NO_CC;
				end else if (packet_byte[7]) begin
					if (hlen_q < cpp_pkg::LEN_TC_MIN) begin
						err_n = cpp_pkg::ST_TC_SHORT;
					end
				end else if (hlen_q < cpp_pkg::LEN_NOTC_MIN) begin
					err_n = cpp_pkg::ST_CC_SHORT;
				end
			end
		end else if (err_q == cpp_pkg::ST_OK) begin
			if (tc && pos_q >= cpp_pkg::POS_TC_MARKER && pos_q <= cpp_pkg::POS_TC_FRAMES) begin
				if (pos_q == cpp_pkg::POS_TC_MARKER) begin
					if (packet_byte != cpp_pkg::TC_MARKER) begin
						err_n = cpp_pkg::ST_TC_MARKER;
					end
				end else if (pos_q == cpp_pkg::POS_TC_HOURS) begin
					if (packet_byte[7:6] != 2'b11) begin
						err_n = cpp_pkg::ST_TC_HOURS;
					end else begin
						bcd_tmp = cpp_pkg::bcd_value({1'b0, packet_byte[5:4]},
							packet_byte[3:0]);
						hours_n = bcd_tmp[5:0];
					end
				end else if (pos_q == cpp_pkg::POS_TC_MIN) begin
					if (!packet_byte[7]) begin
						err_n = cpp_pkg::ST_TC_MINUTES;
					end else begin
						min_n = cpp_pkg::bcd_value(packet_byte[6:4], packet_byte[3:0]);
					end
				end else if (pos_q == cpp_pkg::POS_TC_SEC) begin
					sec_n    = cpp_pkg::bcd_value(packet_byte[6:4], packet_byte[3:0]);
					sfield_n = packet_byte[7];
				end else begin
					if (packet_byte[6]) begin
						err_n = cpp_pkg::ST_TC_FRAMES;
					end else begin
						bcd_tmp  = cpp_pkg::bcd_value({1'b0, packet_byte[5:4]},
							packet_byte[3:0]);
						frames_n = bcd_tmp[5:0];
						drop_n   = packet_byte[7];
						if (hlen_q < cpp_pkg::LEN_TC_FULL) begin
							err_n = cpp_pkg::ST_CC_SHORT;
						end
					end
				end
			end else if (pos_q == cc_start) begin
				if (packet_byte != cpp_pkg::CC_MARKER) begin
					err_n = cpp_pkg::ST_CC_MARKER;
				end
			end else if (pos_q == cc_start + 8'd1) begin
				if (packet_byte[7:5] != 3'b111) begin
					err_n = cpp_pkg::ST_CC_RESERVED;
				end else if (h9 < need || (h9 - need) < cnt3) begin
					err_n = cpp_pkg::ST_CC_SHORT;
				end else begin
					exp_n = packet_byte[4:0];
				end
			end else if (pos_q >= cc_start + 8'd2 && tidx_q < exp_q) begin
				// assemble triplet, written to the store on its third byte
				if (phase_q == 2'd2) begin
					wr_en   = ({1'b0, tidx_q} < {1'b0, MAX_CNT});
					phase_n = 2'd0;
					tidx_n  = tidx_q + 5'd1;
				end else begin
					part_n  = {part_q[7:0], packet_byte};
					phase_n = phase_q + 2'd1;
				end
			end
		end

		if (acc && final_byte) begin
			if (pos_q < cpp_pkg::MIN_LENGTH) begin
				fin_status = cpp_pkg::ST_SHORT;
			end else if (!magic_q) begin
				fin_status = cpp_pkg::ST_MAGIC;
			end else if (pos_q == cpp_pkg::POS_MAX || h9 != {1'b0, pos_q} + 9'd1) begin
				fin_status = cpp_pkg::ST_LENGTH;
			end else begin
				fin_status = err_n;
			end

			push = 1'b1;
			push_desc.status = fin_status;
			push_desc.bank   = bank_q;
			if (fin_status == cpp_pkg::ST_OK) begin
				push_desc.count      = (exp_n > MAX_CNT) ? MAX_CNT : exp_n;
				push_desc.rate       = rate_q;
				push_desc.tc_present = tc;
				if (tc) begin
					push_desc.hours        = hours_n;
					push_desc.minutes      = min_n;
					push_desc.seconds      = sec_n;
					push_desc.frames       = frames_n;
					push_desc.second_field = sfield_n;
					push_desc.drop_frame   = drop_n;
				end
			end

			pos_n    = '0;
			hlen_n   = '0;
			err_n    = cpp_pkg::ST_OK;
			flags_n  = '0;
			rate_n   = '0;
			exp_n    = '0;
			magic_n  = 1'b0;
			tidx_n   = '0;
			phase_n  = '0;
			hours_n  = '0;
			min_n    = '0;
			sec_n    = '0;
			frames_n = '0;
			sfield_n = 1'b0;
			drop_n   = 1'b0;
			bank_n   = ~bank_q;
		end else begin
			pos_n = (pos_q == cpp_pkg::POS_MAX) ? cpp_pkg::POS_MAX : pos_q + 8'd1;
		end

		if (!acc) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			part_q <= part_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hlen_q   <= '0;
			err_q    <= cpp_pkg::ST_OK;
			flags_q  <= '0;
			rate_q   <= '0;
			exp_q    <= '0;
			magic_q  <= 1'b0;
			tidx_q   <= '0;
			phase_q  <= '0;
			bank_q   <= 1'b0;
			hours_q  <= '0;
			min_q    <= '0;
			sec_q    <= '0;
			frames_q <= '0;
			sfield_q <= 1'b0;
			drop_q   <= 1'b0;
		end else if (acc) begin
			pos_q    <= pos_n;
			hlen_q   <= hlen_n;
			err_q    <= err_n;
			flags_q  <= flags_n;
			rate_q   <= rate_n;
			exp_q    <= exp_n;
			magic_q  <= magic_n;
			tidx_q   <= tidx_n;
			phase_q  <= phase_n;
			bank_q   <= bank_n;
			hours_q  <= hours_n;
			min_q    <= min_n;
			sec_q    <= sec_n;
			frames_q <= frames_n;
			sfield_q <= sfield_n;
			drop_q   <= drop_n;
		end
	end

endmodule

@@ rtl/cpp_back.sv @@
module cpp_back #(
	parameter int MAX_TRIPLETS = 31,
	parameter int TW           = $clog2(MAX_TRIPLETS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [TW:0]         wr_addr,
	input  logic [23:0]         wr_data,
	input  logic                fifo_empty,
	input  cpp_pkg::cpp_desc_t  head,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [3:0]          status,
	output logic [23:0]         cc_triplet,
	output logic [4:0]          triplet_count,
	output logic [7:0]          rate_code,
	output logic                timecode_present,
	output logic [5:0]          tc_hours,
	output logic [6:0]          tc_minutes,
	output logic [6:0]          tc_seconds,
	output logic [5:0]          tc_frames,
	output logic                second_field,
	output logic                drop_frame,
	output logic                last_result
);

	localparam int DEPTH = 2 << TW;

	// two banks: one filled by the parser while the other drains
	logic [23:0] store_mem [DEPTH];
	logic [23:0] rd_data_q;
	logic [TW:0] rd_addr;

	cpp_pkg::cpp_back_state_t state_q, state_n;
	logic [4:0]  idx_q, idx_n;
	logic [4:0]  idx_inc;
	logic        is_last;
	logic        load;
	logic        valid_q, valid_n;

	cpp_pkg::cpp_desc_t out_q;
	logic [23:0] trip_q;
	logic        last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpp_pkg::BK_IDLE;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			valid_q <= valid_n;
		end
	end

	always_comb begin
		state_n = state_q;
		idx_n   = idx_q;
		valid_n = valid_q;
		pop     = 1'b0;
		load    = 1'b0;
		idx_inc = idx_q + 5'd1;
		is_last = (head.count == 5'd0) || ({1'b0, idx_inc} >= {1'b0, head.count});
		rd_addr = {head.bank, idx_q[TW-1:0]};

		unique case (state_q)
			cpp_pkg::BK_IDLE: begin
				if (!fifo_empty) begin
					state_n = cpp_pkg::BK_READ;
				end
			end
			cpp_pkg::BK_READ: begin
				load    = 1'b1;
				valid_n = 1'b1;
				state_n = cpp_pkg::BK_SHOW;
			end
			cpp_pkg::BK_SHOW: begin
				if (!result_stall) begin
					valid_n = 1'b0;
					if (last_q) begin
						pop     = 1'b1;
						idx_n   = '0;
						state_n = cpp_pkg::BK_IDLE;
					end else begin
						idx_n   = idx_inc;
						rd_addr = {head.bank, idx_inc[TW-1:0]};
						state_n = cpp_pkg::BK_READ;
					end
				end
			end
			default: begin
				state_n = cpp_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= head;
			trip_q <= (head.count == 5'd0) ? 24'd0 : rd_data_q;
			last_q <= is_last;
		end
	end

	assign result_valid     = valid_q;
	assign status           = out_q.status;
	assign cc_triplet       = trip_q;
	assign triplet_count    = out_q.count;
	assign rate_code        = out_q.rate;
	assign timecode_present = out_q.tc_present;
	assign tc_hours         = out_q.hours;
	assign tc_minutes       = out_q.minutes;
	assign tc_seconds       = out_q.seconds;
	assign tc_frames        = out_q.frames;
	assign second_field     = out_q.second_field;
	assign drop_frame       = out_q.drop_frame;
	assign last_result      = last_q;

endmodule

@@ rtl/caption_packet_parser.sv @@
// Caption distribution packet parser.
// Input channel: one packet byte per transaction (packet_byte, final_byte on
// the last byte), handshake byte_valid / byte_stall. Bytes are taken one per
// cycle while byte_stall is low; the header, time code and cc_data sections
// are checked on the fly; caption triplets go into a two-bank triplet store.
// Output channel: result_valid / result_stall. A packet yields one status
// transaction on error or on success without triplets, otherwise one
// transaction per triplet; last_result marks the final one.
// The summary of a finished packet enters the queue; the output side then
// reads the triplet store (registered) and loads the output register.
// result_valid drops between results while the next triplet is read.
// A packet summary waits in a two-entry queue, so the parser takes the next
// packet while the previous one drains; byte_stall rises only when two
// finished packets are still waiting to be delivered.
// Output stall holds the current result and never affects parsing until the
// queue fills. Reset clears all packet state and the queue; the triplet
// store needs no clearing.
module caption_packet_parser #(
	parameter int MAX_TRIPLETS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  packet_byte,
	input  logic        final_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  status,
	output logic [23:0] cc_triplet,
	output logic [4:0]  triplet_count,
	output logic [7:0]  rate_code,
	output logic        timecode_present,
	output logic [5:0]  tc_hours,
	output logic [6:0]  tc_minutes,
	output logic [6:0]  tc_seconds,
	output logic [5:0]  tc_frames,
	output logic        second_field,
	output logic        drop_frame,
	output logic        last_result
);

	localparam int TW = $clog2(MAX_TRIPLETS + 1);

	logic               fifo_full;
	logic               fifo_empty;
	logic               push;
	logic               pop;
	cpp_pkg::cpp_desc_t push_desc;
	cpp_pkg::cpp_desc_t head;
	logic               wr_en;
	logic [TW:0]        wr_addr;
	logic [23:0]        wr_data;

	cpp_front #(
		.MAX_TRIPLETS(MAX_TRIPLETS),
		.TW(TW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.packet_byte(packet_byte),
		.final_byte (final_byte),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_desc  (push_desc),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	cpp_desc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_desc(push_desc),
		.pop      (pop),
		.head     (head),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	cpp_back #(
		.MAX_TRIPLETS(MAX_TRIPLETS),
		.TW(TW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.fifo_empty      (fifo_empty),
		.head            (head),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.status          (status),
		.cc_triplet      (cc_triplet),
		.triplet_count   (triplet_count),
		.rate_code       (rate_code),
		.timecode_present(timecode_present),
		.tc_hours        (tc_hours),
		.tc_minutes      (tc_minutes),
		.tc_seconds      (tc_seconds),
		.tc_frames       (tc_frames),
		.second_field    (second_field),
		.drop_frame      (drop_frame),
		.last_result     (last_result)
	);

endmodule

@@ tb/sv/tb_caption_packet_parser.sv @@
module tb_caption_packet_parser;
	import cpp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cdp_byte_t;

	typedef struct packed {
		cpp_status_t status;
		logic [23:0] triplet;
		logic [4:0]  count;
		logic [7:0]  rate;
		logic        tc_present;
		logic [5:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [5:0]  frames;
		logic        second_fld;
		logic        drop_fld;
		logic        last;
	} caption_result_t;

	typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_t;
	typedef enum int {
		FAULT_NONE, FAULT_FLIP, FAULT_POKE, FAULT_TRUNCATE, FAULT_APPEND, FAULT_LENGTH,
		FAULT_NOISE
	} fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  packet_byte = 8'd0;
	logic        final_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [3:0]  status;
	logic [23:0] cc_triplet;
	logic [4:0]  triplet_count;
	logic [7:0]  rate_code;
	logic        timecode_present;
	logic [5:0]  tc_hours;
	logic [6:0]  tc_minutes;
	logic [6:0]  tc_seconds;
	logic [5:0]  tc_frames;
	logic        second_field;
	logic        drop_frame;
	logic        last_result;

	caption_packet_parser dut (.*);

	always #5 clk = ~clk;

	cdp_byte_t       pending_bytes[$];
	caption_result_t expected_results[$];
	logic [7:0]      pkt[$];
	int              mismatches = 0;
	bit              byte_taken = 1'b0;

	// parser shadow state
	logic [7:0]  p_pos, p_hlen, p_flags, p_rate;
	cpp_status_t p_err;
	logic [4:0]  p_count;
	logic [23:0] p_store[31];
	logic [23:0] p_partial;
	logic [5:0]  p_hours, p_frames;
	logic [6:0]  p_minutes, p_seconds;
	logic        p_second_fld, p_drop_fld, p_magic;

	function automatic void clear_packet();
		p_pos = 8'd0;
		p_hlen = 8'd0;
		p_flags = 8'd0;
		p_rate = 8'd0;
		p_err = ST_OK;
		p_count = 5'd0;
		p_partial = 24'd0;
		p_hours = 6'd0;
		p_frames = 6'd0;
		p_minutes = 7'd0;
		p_seconds = 7'd0;
		p_second_fld = 1'b0;
		p_drop_fld = 1'b0;
		p_magic = 1'b0;
	endfunction

	function automatic void note_error(cpp_status_t code);
		if (p_err == ST_OK)
			p_err = code;
	endfunction

	function automatic int bcd_digits(logic [7:0] b, logic [2:0] tens_mask);
		return int'(b[6:4] & tens_mask) * 10 + int'(b[3:0]);
	endfunction

	// Advance the shadow parser by one byte; on the last byte queue the results.
	function automatic void parse_byte(logic [7:0] b, logic fin);
		int idx, h, s, k, n, cnt;
		bit tc;
		cpp_status_t verdict;
		caption_result_t r;
		idx = p_pos;
		h = p_hlen;
		if (idx <= POS_FLAGS) begin
			case (idx)
			POS_MAGIC_HI: p_magic = (b == MAGIC_HI);
			POS_MAGIC_LO: p_magic = p_magic && (b == MAGIC_LO);
			POS_LENGTH: p_hlen = b;
			POS_RATE: begin
				p_rate = b;
				if (!(b[3:0] == 4'hf && b[7:4] >= 4'd1 && b[7:4] <= 4'd8))
					note_error(ST_RATE);
			end
			default: begin
				p_flags = b;
				if (!b[6])
					note_error(ST_NO_CC);
				else if (b[7]) begin
					if (h < LEN_TC_MIN)
						note_error(ST_TC_SHORT);
				end else if (h < LEN_NOTC_MIN)
					note_error(ST_CC_SHORT);
			end
			endcase
		end else if (p_err == ST_OK) begin
			tc = p_flags[7];
			s = tc ? CC_START_TC : CC_START_NOTC;
			if (tc && idx >= POS_TC_MARKER && idx <= POS_TC_FRAMES) begin
				case (idx)
				POS_TC_MARKER: if (b != TC_MARKER) note_error(ST_TC_MARKER);
				POS_TC_HOURS: begin
					if (b[7:6] != 2'b11) note_error(ST_TC_HOURS);
					else p_hours = 6'(bcd_digits(b, 3'd3));
				end
				POS_TC_MIN: begin
					if (!b[7]) note_error(ST_TC_MINUTES);
					else p_minutes = 7'(bcd_digits(b, 3'd7));
				end
				POS_TC_SEC: begin
					p_seconds = 7'(bcd_digits(b, 3'd7));
					p_second_fld = b[7];
				end
				default: begin
					if (b[6]) note_error(ST_TC_FRAMES);
					else begin
						p_frames = 6'(bcd_digits(b, 3'd3));
						p_drop_fld = b[7];
						if (h < LEN_TC_FULL) note_error(ST_CC_SHORT);
					end
				end
				endcase
			end else if (idx == s) begin
				if (b != CC_MARKER) note_error(ST_CC_MARKER);
			end else if (idx == s + 1) begin
				cnt = int'(b[4:0]);
				if (b[7:5] != 3'b111) note_error(ST_CC_RESERVED);
				else if (h < s + 2 || h - (s + 2) < 3 * cnt) note_error(ST_CC_SHORT);
				else p_count = b[4:0];
			end else if (idx >= s + 2) begin
				k = idx - (s + 2);
				if (k < 3 * int'(p_count)) begin
					p_partial = {p_partial[15:0], b};
					if (k % 3 == 2) begin
						p_store[k / 3] = p_partial;
						p_partial = 24'd0;
					end
				end
			end
		end

		if (!fin) begin
			p_pos = (p_pos == POS_MAX) ? POS_MAX : p_pos + 8'd1;
			return;
		end

		if (idx < MIN_LENGTH) verdict = ST_SHORT;
		else if (!p_magic) verdict = ST_MAGIC;
		else if (idx == POS_MAX || int'(p_hlen) != idx + 1) verdict = ST_LENGTH;
		else verdict = p_err;

		if (verdict != ST_OK) begin
			r = '0;
			r.status = verdict;
			r.last = 1'b1;
			expected_results.push_back(r);
		end else begin
			n = p_count;
			for (int j = 0; j < ((n == 0) ? 1 : n); j++) begin
				r = '0;
				r.status = ST_OK;
				r.triplet = (n == 0) ? 24'd0 : p_store[j];
				r.count = 5'(n);
				r.rate = p_rate;
				r.tc_present = p_flags[7];
				// time code fields stay zero unless the flag announced them
				r.hours = p_hours;
				r.minutes = p_minutes;
				r.seconds = p_seconds;
				r.frames = p_frames;
				r.second_fld = p_second_fld;
				r.drop_fld = p_drop_fld;
				r.last = (j + 1 >= n);
				expected_results.push_back(r);
			end
		end
		clear_packet();
	endfunction

	// well-formed packet with random content
	function automatic void build_packet(bit with_tc, int n_trip, int footer);
		int s;
		s = with_tc ? CC_START_TC : CC_START_NOTC;
		pkt.delete();
		pkt.push_back(MAGIC_HI);
		pkt.push_back(MAGIC_LO);
		pkt.push_back(8'(s + 2 + 3 * n_trip + footer));
		pkt.push_back({4'($urandom_range(1, 8)), 4'hf});
		pkt.push_back({with_tc, 1'b1, 6'($urandom)});
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		if (with_tc) begin
			pkt.push_back(TC_MARKER);
			pkt.push_back({2'b11, 6'($urandom)});
			pkt.push_back({1'b1, 7'($urandom)});
			pkt.push_back(8'($urandom));
			pkt.push_back({1'($urandom), 1'b0, 6'($urandom)});
		end
		pkt.push_back(CC_MARKER);
		pkt.push_back({3'b111, 5'(n_trip)});
		repeat (3 * n_trip + footer) pkt.push_back(8'($urandom));
	endfunction

	function automatic void send_packet();
		cdp_byte_t t;
		foreach (pkt[i]) begin
			t.data = pkt[i];
			t.last = (i == pkt.size() - 1);
			pending_bytes.push_back(t);
		end
	endfunction

	function automatic void cut_packet(int len);
		while (pkt.size() > len) pkt.delete(pkt.size() - 1);
	endfunction

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// input side: acceptance and prediction
	always @(posedge clk) begin
		byte_taken = 1'b0;
		if (arst_n && byte_valid && !byte_stall) begin
			byte_taken = 1'b1;
			parse_byte(packet_byte, final_byte);
			pending_bytes.delete(0);
		end
	end

	// sender: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (byte_valid && !byte_taken) begin
			// stalled transaction stays put
		end else if (gap_left > 0) begin
			byte_valid <= 1'b0;
			gap_left--;
		end else if (pending_bytes.size() > 0) begin
			byte_valid <= 1'b1;
			packet_byte <= pending_bytes[0].data;
			final_byte <= pending_bytes[0].last;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end else begin
			byte_valid <= 1'b0;
		end
	end

	// receiver stall pattern
	sink_mode_t sink_mode = SINK_FREE;
	int sink_left = 0;
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(SINK_FREE, SINK_TOGGLE));
			sink_left = $urandom_range(20, 200);
		end else begin
			sink_left--;
		end
		case (sink_mode)
		SINK_FREE: result_stall <= 1'b0;
		SINK_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
		SINK_HEAVY: result_stall <= ($urandom_range(0, 9) < 8);
		default: result_stall <= ~result_stall;
		endcase
	end

	function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		caption_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected, status %0d", status);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, status);
				check_field("cc_triplet", want.triplet, cc_triplet);
				check_field("triplet_count", want.count, triplet_count);
				check_field("rate_code", want.rate, rate_code);
				check_field("timecode_present", want.tc_present, timecode_present);
				check_field("tc_hours", want.hours, tc_hours);
				check_field("tc_minutes", want.minutes, tc_minutes);
				check_field("tc_seconds", want.seconds, tc_seconds);
				check_field("tc_frames", want.frames, tc_frames);
				check_field("second_field", want.second_fld, second_field);
				check_field("drop_frame", want.drop_fld, drop_frame);
				check_field("last_result", want.last, last_result);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [7:0] bad_rates[3] = '{8'h0f, 8'h9f, 8'h1e};
		int n_pkts, n_bytes, r, n_trip;
		fault_t fault;

		clear_packet();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// shortest good packet, lowest valid rate
		build_packet(1'b0, 0, 2);
		pkt[POS_RATE] = 8'h1f;
		send_packet();
		// largest BCD digits, highest valid rate
		build_packet(1'b1, 1, 4);
		pkt[POS_RATE] = 8'h8f;
		pkt[POS_TC_HOURS] = 8'hff;
		pkt[POS_TC_MIN] = 8'hff;
		pkt[POS_TC_SEC] = 8'hff;
		pkt[POS_TC_FRAMES] = 8'hbf;
		send_packet();
		// full triplet load, smallest time code
		build_packet(1'b1, 31, 4);
		pkt[POS_TC_HOURS] = 8'hc0;
		pkt[POS_TC_MIN] = 8'h80;
		pkt[POS_TC_SEC] = 8'h00;
		pkt[POS_TC_FRAMES] = 8'h00;
		for (int i = 14; i < 17; i++) pkt[i] = 8'hff;
		for (int i = 17; i < 20; i++) pkt[i] = 8'h00;
		send_packet();
		// no footer at all
		build_packet(1'b0, 3, 0);
		send_packet();
		// longest length the header can carry
		build_packet(1'b1, 31, 148);
		send_packet();
		// too short
		build_packet(1'b0, 0, 2);
		cut_packet(10);
		send_packet();
		pkt.delete();
		pkt.push_back(MAGIC_HI);
		send_packet();
		// bad magic, both bytes
		build_packet(1'b1, 2, 4);
		pkt[POS_MAGIC_HI] = 8'h97;
		send_packet();
		build_packet(1'b0, 2, 4);
		pkt[POS_MAGIC_LO] = 8'h68;
		send_packet();
		// length byte mismatch
		build_packet(1'b0, 1, 4);
		pkt[POS_LENGTH] = pkt[POS_LENGTH] + 8'd1;
		send_packet();
		foreach (bad_rates[i]) begin
			build_packet(1'b0, 1, 2);
			pkt[POS_RATE] = bad_rates[i];
			send_packet();
		end
		// cc_data flag missing
		build_packet(1'b1, 1, 2);
		pkt[POS_FLAGS] = 8'h80;
		send_packet();
		// time code announced but no room for it
		build_packet(1'b1, 0, 0);
		cut_packet(11);
		pkt[POS_LENGTH] = 8'd11;
		send_packet();
		build_packet(1'b1, 1, 2);
		pkt[POS_TC_MARKER] = 8'h70;
		send_packet();
		build_packet(1'b1, 1, 2);
		pkt[POS_TC_HOURS] = 8'h40;
		send_packet();
		build_packet(1'b1, 1, 2);
		pkt[POS_TC_MIN] = 8'h7f;
		send_packet();
		build_packet(1'b1, 1, 2);
		pkt[POS_TC_FRAMES] = pkt[POS_TC_FRAMES] | 8'h40;
		send_packet();
		// time code ends the packet before the cc_data header
		build_packet(1'b1, 0, 0);
		cut_packet(13);
		pkt[POS_LENGTH] = 8'd13;
		send_packet();
		// triplet count overruns the packet
		build_packet(1'b0, 2, 0);
		pkt[CC_START_NOTC + 1] = 8'he3;
		send_packet();
		build_packet(1'b0, 1, 2);
		pkt[CC_START_NOTC] = 8'h73;
		send_packet();
		build_packet(1'b1, 1, 2);
		pkt[CC_START_TC + 1] = 8'hc1;
		send_packet();
		// byte counter saturates
		build_packet(1'b0, 0, 0);
		while (pkt.size() < 300) pkt.push_back(8'($urandom));
		pkt[POS_LENGTH] = 8'hff;
		send_packet();

		wait_drained();

		n_pkts = 0;
		n_bytes = 0;
		while (n_pkts < 40 || n_bytes < 160) begin
			r = $urandom_range(0, 99);
			if (r < 70) n_trip = $urandom_range(0, 4);
			else if (r < 95) n_trip = $urandom_range(5, 12);
			else n_trip = $urandom_range(13, 31);
			build_packet(1'($urandom), n_trip, $urandom_range(0, 4));
			fault = ($urandom_range(0, 99) < 60) ? FAULT_NONE :
				fault_t'($urandom_range(FAULT_FLIP, FAULT_NOISE));
			case (fault)
			FAULT_FLIP: begin
				r = $urandom_range(0, pkt.size() - 1);
				pkt[r] = pkt[r] ^ (8'd1 << $urandom_range(0, 7));
			end
			FAULT_POKE: pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
			FAULT_TRUNCATE: cut_packet($urandom_range(1, pkt.size() - 1));
			FAULT_APPEND: repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
			FAULT_LENGTH: pkt[POS_LENGTH] = 8'($urandom);
			FAULT_NOISE: begin
				pkt.delete();
				repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
			end
			default: ;
			endcase
			send_packet();
			n_bytes += pkt.size();
			n_pkts++;
			if (n_pkts == 20)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
